>>> src/binary_min_heap_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue
// Shared shorthand for the concurrent checks of the queue's control logic.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Shared widths, request and response types, control codes and the
// microcode program that sequences push and pop.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Storage and field widths.
    localparam int DEPTH    = 64;
    localparam int KEY_W    = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 4;
    localparam int COND_W   = 3;

    // Operation codes.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Jump conditions.
    localparam logic [COND_W-1:0] C_NEVER       = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 3'd1;
    localparam logic [COND_W-1:0] C_POS_ZERO    = 3'd2;
    localparam logic [COND_W-1:0] C_NOT_GREATER = 3'd3;
    localparam logic [COND_W-1:0] C_LEAF        = 3'd4;
    localparam logic [COND_W-1:0] C_POS_LAST    = 3'd5;
    localparam logic [COND_W-1:0] C_FULL        = 3'd6;
    localparam logic [COND_W-1:0] C_EMPTY       = 3'd7;

    // Read port A address sources.
    localparam logic [1:0] RDA_PARENT = 2'd0;
    localparam logic [1:0] RDA_C1     = 2'd1;
    localparam logic [1:0] RDA_LAST   = 2'd2;
    localparam logic [1:0] RDA_ROOT   = 2'd3;

    // Write data sources.
    localparam logic [1:0] WR_CUR   = 2'd0;
    localparam logic [1:0] WR_RDA   = 2'd1;
    localparam logic [1:0] WR_CHILD = 2'd2;

    // Position register operations.
    localparam logic [2:0] POS_HOLD   = 3'd0;
    localparam logic [2:0] POS_FILL   = 3'd1;
    localparam logic [2:0] POS_ZERO   = 3'd2;
    localparam logic [2:0] POS_PARENT = 3'd3;
    localparam logic [2:0] POS_CHILD  = 3'd4;

    // Moving entry register operations.
    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_REQ  = 2'd1;
    localparam logic [1:0] CUR_RDA  = 2'd2;

    // Fill count operations.
    localparam logic [1:0] FILL_HOLD = 2'd0;
    localparam logic [1:0] FILL_INC  = 2'd1;
    localparam logic [1:0] FILL_DEC  = 2'd2;

    // Program step addresses.
    localparam logic [STEP_W-1:0] S_PUSH      = 4'd0;
    localparam logic [STEP_W-1:0] S_UP        = 4'd1;
    localparam logic [STEP_W-1:0] S_UP_CMP    = 4'd2;
    localparam logic [STEP_W-1:0] S_UP_BACK   = 4'd3;
    localparam logic [STEP_W-1:0] S_PLACE     = 4'd4;
    localparam logic [STEP_W-1:0] S_DONE      = 4'd5;
    localparam logic [STEP_W-1:0] S_POP       = 4'd6;
    localparam logic [STEP_W-1:0] S_POP_ROOT  = 4'd7;
    localparam logic [STEP_W-1:0] S_DOWN      = 4'd8;
    localparam logic [STEP_W-1:0] S_DOWN_SEL  = 4'd9;
    localparam logic [STEP_W-1:0] S_LEAF      = 4'd10;
    localparam logic [STEP_W-1:0] S_LOAD_LAST = 4'd11;

    typedef struct packed {
        logic              mode;
        logic [KEY_W-1:0]  priority_req;
        logic [DATA_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   popped_payload;
        logic [IDX_W-1:0]    slot;
        logic [CNT_W-1:0]    count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_entry;

    // One control word of the program.
    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
        logic [1:0]        rda_sel;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic [2:0]        pos_op;
        logic [1:0]        cur_op;
        logic              pop_load;
        logic              done;
    } t_uword;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic [1:0] rda_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [2:0] pos_op;
        logic [1:0] cur_op;
        logic       pop_load;
        logic [1:0] fill_op;
        t_entry     req_entry;
    } t_dp_ctrl;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic pos_zero;
        logic not_greater;
        logic leaf;
        logic pos_last;
        logic full;
        logic empty;
    } t_dp_flags;

    function automatic t_uword uw(
        input logic [COND_W-1:0] cond,
        input logic [STEP_W-1:0] target,
        input logic [1:0]        rda_sel,
        input logic              wr_en,
        input logic [1:0]        wr_sel,
        input logic [2:0]        pos_op,
        input logic [1:0]        cur_op,
        input logic              pop_load,
        input logic              done
    );
        t_uword word;
        word.cond     = cond;
        word.target   = target;
        word.rda_sel  = rda_sel;
        word.wr_en    = wr_en;
        word.wr_sel   = wr_sel;
        word.pos_op   = pos_op;
        word.cur_op   = cur_op;
        word.pop_load = pop_load;
        word.done     = done;
        return word;
    endfunction

    // Microcode program. Actions of a step with a conditional jump take
    // effect only when the jump is not taken.
    function automatic t_uword bmhq_ucode(input logic [STEP_W-1:0] step);
        t_uword word;
        case (step)
            // Push: reject when full, else start at the first free slot.
            S_PUSH: word = uw(C_FULL, S_DONE, RDA_ROOT, 1'b0, WR_CUR,
                              POS_FILL, CUR_REQ, 1'b0, 1'b0);
            // Sift-up: fetch the parent unless the hole is at the root.
            S_UP: word = uw(C_POS_ZERO, S_PLACE, RDA_PARENT, 1'b0, WR_CUR,
                            POS_HOLD, CUR_HOLD, 1'b0, 1'b0);
            // Move a greater parent down into the hole and climb.
            S_UP_CMP: word = uw(C_NOT_GREATER, S_PLACE, RDA_PARENT, 1'b1, WR_RDA,
                                POS_PARENT, CUR_HOLD, 1'b0, 1'b0);
            S_UP_BACK: word = uw(C_ALWAYS, S_UP, RDA_PARENT, 1'b0, WR_CUR,
                                 POS_HOLD, CUR_HOLD, 1'b0, 1'b0);
            // Drop the moving entry into the hole and finish.
            S_PLACE: word = uw(C_NEVER, S_DONE, RDA_ROOT, 1'b1, WR_CUR,
                               POS_HOLD, CUR_HOLD, 1'b0, 1'b1);
            // Pop: reject when empty, else read the root.
            S_POP: word = uw(C_EMPTY, S_DONE, RDA_ROOT, 1'b0, WR_CUR,
                             POS_HOLD, CUR_HOLD, 1'b0, 1'b0);
            S_POP_ROOT: word = uw(C_NEVER, S_DONE, RDA_ROOT, 1'b0, WR_CUR,
                                  POS_ZERO, CUR_HOLD, 1'b1, 1'b0);
            // Descent: fetch both children unless the hole is a leaf.
            S_DOWN: word = uw(C_LEAF, S_LEAF, RDA_C1, 1'b0, WR_CUR,
                              POS_HOLD, CUR_HOLD, 1'b0, 1'b0);
            S_DOWN_SEL: word = uw(C_ALWAYS, S_DOWN, RDA_C1, 1'b1, WR_CHILD,
                                  POS_CHILD, CUR_HOLD, 1'b0, 1'b0);
            // At the leaf: done if it is the last slot, else move the last in.
            S_LEAF: word = uw(C_POS_LAST, S_DONE, RDA_LAST, 1'b0, WR_CUR,
                              POS_HOLD, CUR_HOLD, 1'b0, 1'b0);
            S_LOAD_LAST: word = uw(C_ALWAYS, S_UP, RDA_LAST, 1'b0, WR_CUR,
                                   POS_HOLD, CUR_RDA, 1'b0, 1'b0);
            default: word = uw(C_NEVER, S_DONE, RDA_ROOT, 1'b0, WR_CUR,
                               POS_HOLD, CUR_HOLD, 1'b0, 1'b1);
        endcase
        return word;
    endfunction

endpackage

>>> src/bmhq_dp.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue datapath
// Entry memory with two registered read ports, the hole position, the
// moving entry, the fill count and the flags that steer the program.
// ----------------------------------------------------------------------------
module bmhq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmhq_pkg::t_dp_ctrl            i_ctrl,
    output bmhq_pkg::t_dp_flags           o_flags,
    output logic [bmhq_pkg::CNT_W-1:0]    o_fill,
    output logic [bmhq_pkg::DATA_W-1:0]   o_popped
);
    import bmhq_pkg::*;

    t_entry              r_mem [DEPTH];
    t_entry              r_rd_a;
    t_entry              r_rd_b;
    t_entry              r_cur;
    t_entry              n_cur;
    t_entry              child;
    t_entry              wr_data;
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    n_pos;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic [DATA_W-1:0]   r_popped;
    logic [CNT_W-1:0]    c1;
    logic [CNT_W:0]      c2;
    logic                c2_out;
    logic [IDX_W-1:0]    pos_m1;
    logic [IDX_W-1:0]    parent;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    child_idx;
    logic [IDX_W-1:0]    addr_a;
    logic                pick_b;

    // Tree arithmetic around the hole position.
    always_comb begin
        c1        = {r_pos, 1'b1};
        c2        = {1'b0, r_pos, 1'b0} + (CNT_W+1)'(2);
        c2_out    = c2 >= {1'b0, r_fill};
        pos_m1    = r_pos - IDX_W'(1);
        parent    = {1'b0, pos_m1[IDX_W-1:1]};
        last_idx  = r_fill[IDX_W-1:0] - IDX_W'(1);
        pick_b    = !(c2_out || (r_rd_a.key < r_rd_b.key));
        child     = pick_b ? r_rd_b : r_rd_a;
        child_idx = pick_b ? c2[IDX_W-1:0] : c1[IDX_W-1:0];
    end

    // Flags for the jump conditions.
    always_comb begin
        o_flags.pos_zero    = (r_pos == '0);
        o_flags.not_greater = !(r_rd_a.key > r_cur.key);
        o_flags.leaf        = (c1 >= r_fill);
        o_flags.pos_last    = ({1'b0, r_pos} == (r_fill - CNT_W'(1)));
        o_flags.full        = (r_fill == CNT_W'(DEPTH));
        o_flags.empty       = (r_fill == '0);
    end

    // Read address and write data selection.
    always_comb begin
        case (i_ctrl.rda_sel)
            RDA_PARENT: addr_a = parent;
            RDA_C1:     addr_a = c1[IDX_W-1:0];
            RDA_LAST:   addr_a = last_idx;
            RDA_ROOT:   addr_a = '0;
            default:    addr_a = '0;
        endcase
        case (i_ctrl.wr_sel)
            WR_CUR:   wr_data = r_cur;
            WR_RDA:   wr_data = r_rd_a;
            WR_CHILD: wr_data = child;
            default:  wr_data = r_cur;
        endcase
    end

    // Next values of the position, moving entry and fill count.
    always_comb begin
        case (i_ctrl.pos_op)
            POS_HOLD:   n_pos = r_pos;
            POS_FILL:   n_pos = r_fill[IDX_W-1:0];
            POS_ZERO:   n_pos = '0;
            POS_PARENT: n_pos = parent;
            POS_CHILD:  n_pos = child_idx;
            default:    n_pos = r_pos;
        endcase
        case (i_ctrl.cur_op)
            CUR_HOLD: n_cur = r_cur;
            CUR_REQ:  n_cur = i_ctrl.req_entry;
            CUR_RDA:  n_cur = r_rd_a;
            default:  n_cur = r_cur;
        endcase
        case (i_ctrl.fill_op)
            FILL_HOLD: n_fill = r_fill;
            FILL_INC:  n_fill = r_fill + CNT_W'(1);
            FILL_DEC:  n_fill = r_fill - CNT_W'(1);
            default:   n_fill = r_fill;
        endcase
    end

    // Entry memory: one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[c2[IDX_W-1:0]];
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_cur <= n_cur;
        if (i_ctrl.pop_load) begin
            r_popped <= r_rd_a.data;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_fill   = r_fill;
    assign o_popped = r_popped;

endmodule

>>> src/bmhq_seq.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue sequencer
// Step counter over the microcode program, request and response
// handshakes, status decision and response register.
// ----------------------------------------------------------------------------
module bmhq_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  bmhq_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_stall,
    output bmhq_pkg::t_rsp                o_rsp,
    output bmhq_pkg::t_dp_ctrl            o_ctrl,
    input  bmhq_pkg::t_dp_flags           i_flags,
    input  logic [bmhq_pkg::CNT_W-1:0]    i_fill,
    input  logic [bmhq_pkg::DATA_W-1:0]   i_popped
);
    import bmhq_pkg::*;

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    t_req                  r_req;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic [IDX_W-1:0]      r_slot;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;
    t_uword                word;
    logic                  cond_hit;
    logic                  rsp_free;
    logic                  advance;
    logic                  finish;
    logic                  act;
    logic                  op_ok;
    logic                  accept;
    logic [1:0]            fill_op;
    logic [CNT_W-1:0]      count_after;

    // Current control word and its jump condition.
    always_comb begin
        word = bmhq_ucode(r_step);
        case (word.cond)
            C_NEVER:       cond_hit = 1'b0;
            C_ALWAYS:      cond_hit = 1'b1;
            C_POS_ZERO:    cond_hit = i_flags.pos_zero;
            C_NOT_GREATER: cond_hit = i_flags.not_greater;
            C_LEAF:        cond_hit = i_flags.leaf;
            C_POS_LAST:    cond_hit = i_flags.pos_last;
            C_FULL:        cond_hit = i_flags.full;
            C_EMPTY:       cond_hit = i_flags.empty;
            default:       cond_hit = 1'b0;
        endcase
    end

    // Step advance, action gating and the fill update at completion.
    always_comb begin
        rsp_free = !r_rsp_valid || !i_rsp_stall;
        advance  = r_busy && (!word.done || rsp_free);
        finish   = advance && word.done;
        act      = advance && !(cond_hit && (word.cond != C_ALWAYS));
        op_ok    = (r_status == ST_OK);
        accept   = i_req_valid && !r_busy;
        fill_op  = FILL_HOLD;
        if (finish && op_ok) begin
            fill_op = (r_req.mode == MODE_POP) ? FILL_DEC : FILL_INC;
        end
        case (fill_op)
            FILL_INC: count_after = i_fill + CNT_W'(1);
            FILL_DEC: count_after = i_fill - CNT_W'(1);
            default:  count_after = i_fill;
        endcase
    end

    // Status of a new request, decided from the fill count at acceptance.
    always_comb begin
        n_status = ST_OK;
        if ((i_req.mode == MODE_POP) && i_flags.empty) begin
            n_status = ST_EMPTY;
        end else if ((i_req.mode == MODE_PUSH) && i_flags.full) begin
            n_status = ST_FULL;
        end
    end

    // Datapath commands.
    always_comb begin
        o_ctrl.rda_sel       = word.rda_sel;
        o_ctrl.wr_en         = act && word.wr_en;
        o_ctrl.wr_sel        = word.wr_sel;
        o_ctrl.pos_op        = act ? word.pos_op : POS_HOLD;
        o_ctrl.cur_op        = act ? word.cur_op : CUR_HOLD;
        o_ctrl.pop_load      = act && word.pop_load;
        o_ctrl.fill_op       = fill_op;
        o_ctrl.req_entry.key  = r_req.priority_req;
        o_ctrl.req_entry.data = r_req.payload;
    end

    // Response assembled at completion.
    always_comb begin
        n_rsp.status         = r_status;
        n_rsp.popped_payload = (op_ok && (r_req.mode == MODE_POP)) ? i_popped : '0;
        n_rsp.slot           = (op_ok && (r_req.mode == MODE_PUSH)) ? r_slot : '0;
        n_rsp.count          = count_after;
    end

    // Control state: busy flag, step counter and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= S_DONE;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= (i_req.mode == MODE_POP) ? S_POP : S_PUSH;
            end else if (advance) begin
                r_step <= cond_hit ? word.target : r_step + STEP_W'(1);
                if (finish) begin
                    r_busy <= 1'b0;
                end
            end
            if (finish) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Request capture and response register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req;
            r_status <= n_status;
            r_slot   <= i_fill[IDX_W-1:0];
        end
        if (finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_req_stall = r_busy;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> src/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue
// Array-backed min-heap of (priority, payload) entries with push and pop,
// run by a microcoded sequencer over a single-memory datapath.
//
//   Channel   Direction  Handshake                  Carries
//   request   in         i_req_valid / o_req_stall  mode, priority_req, payload
//   response  out        o_rsp_valid / i_rsp_stall  status, popped_payload, slot, count
//
// One request is in work at a time; the next is taken the cycle after the
// last one loads its response register, even while that response waits.
// Each heap level is a registered memory read: a push climbs from the first
// free slot toward the root, a pop descends from the root to a leaf and,
// unless the hole ends in the last slot, climbs back with the last entry.
// Reset clears the fill count, the busy flag, step counter and response valid.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module binary_min_heap_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  bmhq_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output bmhq_pkg::t_rsp   o_rsp
);
    import bmhq_pkg::*;

    t_dp_ctrl             ctrl;
    t_dp_flags            flags;
    logic [CNT_W-1:0]     fill;
    logic [DATA_W-1:0]    popped;

    // Sequencer: program counter and handshakes.
    bmhq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .o_ctrl      (ctrl),
        .i_flags     (flags),
        .i_fill      (fill),
        .i_popped    (popped)
    );

    // Datapath: entry memory and working registers.
    bmhq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_flags  (flags),
        .o_fill   (fill),
        .o_popped (popped)
    );

    // The fill count never exceeds the heap depth.
    `BMHQ_ASSERT_ALWAYS(a_fill_bound, fill <= CNT_W'(DEPTH), "fill count above depth")

    // The fill count moves by at most one entry per cycle.
    `BMHQ_ASSERT_NEXT(a_fill_step, 1'b1, fill - $past(fill) + 1'b1 <= 2'd2, "fill count jumped")

    // A pending response reports the fill count the heap really holds.
    `BMHQ_ASSERT_ALWAYS(a_rsp_count, !o_rsp_valid || o_rsp.count == fill, "count differs from fill")

endmodule
